/* design/fsw_pkg.sv */
package fsw_pkg;

	// field widths
	localparam int DELTA_W = 24;
	localparam int RATE_W  = 28;
	localparam int INT_W   = 6;

	// rate numerator: one million frames per second scaled by 256
	localparam logic [RATE_W-1:0] RATE_NUM = 28'd256000000;

	// sequencer program size
	localparam int STEP_W = 4;

	// datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DIV_RATE,
		OP_DIV_STEP,
		OP_STORE,
		OP_WALK,
		OP_DIV_MEAN,
		OP_STAT,
		OP_EMIT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_IN,
		C_SKIP,
		C_DIV_MORE,
		C_WALK_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// divider control
	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// program step addresses
	localparam step_t STEP_WAIT     = 4'd0;
	localparam step_t STEP_RATE     = 4'd1;
	localparam step_t STEP_RATE_DIV = 4'd2;
	localparam step_t STEP_STORE    = 4'd3;
	localparam step_t STEP_WALK     = 4'd4;
	localparam step_t STEP_MEAN     = 4'd5;
	localparam step_t STEP_MEAN_DIV = 4'd6;
	localparam step_t STEP_STAT     = 4'd7;
	localparam step_t STEP_EMIT     = 4'd8;
	localparam step_t STEP_RETURN   = 4'd9;

	// control store
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			STEP_WAIT:     w = '{op: OP_ACCEPT,   cond: C_NO_IN,     target: STEP_WAIT};
			STEP_RATE:     w = '{op: OP_DIV_RATE, cond: C_SKIP,      target: STEP_EMIT};
			STEP_RATE_DIV: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: STEP_RATE_DIV};
			STEP_STORE:    w = '{op: OP_STORE,    cond: C_NEXT,      target: STEP_WAIT};
			STEP_WALK:     w = '{op: OP_WALK,     cond: C_WALK_MORE, target: STEP_WALK};
			STEP_MEAN:     w = '{op: OP_DIV_MEAN, cond: C_NEXT,      target: STEP_WAIT};
			STEP_MEAN_DIV: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: STEP_MEAN_DIV};
			STEP_STAT:     w = '{op: OP_STAT,     cond: C_NEXT,      target: STEP_WAIT};
			STEP_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY,  target: STEP_EMIT};
			STEP_RETURN:   w = '{op: OP_NONE,     cond: C_ALWAYS,    target: STEP_WAIT};
			default:       w = '{op: OP_NONE,     cond: C_ALWAYS,    target: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

/* design/frame_rate_window_statistics.sv */
// Frame rate window statistics.
// One input item per frame tick on the s_ stream: s_tdata is the frame time in
// microseconds. Every tick yields one output item on the m_ stream: m_tuser is
// set when the tick stored a new rate sample, m_tdata carries current, mean,
// minimum and maximum rate (u20.8 frames per second) over the history ring.
// The cfg channel writes the sample interval (ticks between samples); it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. Throughput: one item at a time. A
// tick that does not sample passes the wait, rate, emit and return steps.
// A sampling tick runs the shared bit-serial divider for the rate and the
// mean (28 + clog2(HISTORY_DEPTH+1) bits wide, 36 at the default depth)
// and walks the valid history slots through the memory's single read port.
// The next item is accepted while the previous result waits in the output
// register; a stalled receiver holds the sequencer only at its emit step.
// Reset empties the ring at once through a fill count (no clearing pass),
// zeroes all statistics and sets the sample interval to one.
module frame_rate_window_statistics #(
	parameter int HISTORY_DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fsw_pkg::INT_W-1:0]     cfg_data,   // sample_interval
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,    // delta_us
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [111:0]                  m_tdata,    // current, mean, min, max rate
	output logic                          m_tuser     // recorded
);
	import fsw_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = RATE_W + CW;
	localparam int VW = (CW > DELTA_W) ? CW : DELTA_W;

	// sequencer
	step_t  step_q;
	ucode_t uw;
	logic   jump;

	// datapath registers
	logic [INT_W-1:0]   interval_q;
	logic [INT_W-1:0]   tick_q;
	logic [DELTA_W-1:0] delta_q;
	logic               skip_q;
	logic               rec_q;
	logic [AW-1:0]      wslot_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      wi_q;
	logic               rd_v_s1;
	logic [RATE_W-1:0]  rd_data_s1;
	logic [SW-1:0]      sum_q;
	logic [RATE_W-1:0]  lo_q;
	logic [RATE_W-1:0]  hi_q;
	logic [RATE_W-1:0]  cur_q;
	logic [RATE_W-1:0]  mean_q;
	logic [RATE_W-1:0]  min_q;
	logic [RATE_W-1:0]  max_q;
	logic               m_tvalid_q;
	logic               m_tuser_q;
	logic [111:0]       m_tdata_q;

	logic [RATE_W-1:0]  mem [HISTORY_DEPTH];

	// divider hookup
	div_ctrl_t          div_ctrl;
	logic [SW-1:0]      div_dividend;
	logic [VW-1:0]      div_divisor;
	logic [SW-1:0]      div_quo;
	logic               div_last;

	logic               in_fire;
	logic               out_busy;
	logic               emit_fire;
	logic [INT_W:0]     tick_next;
	logic               sample;

	assign uw        = ucode_rom(step_q);
	assign s_tready  = (uw.op == OP_ACCEPT);
	assign in_fire   = s_tvalid && s_tready;
	assign out_busy  = m_tvalid_q && !m_tready;
	assign emit_fire = (uw.op == OP_EMIT) && !out_busy;
	assign cfg_ready = 1'b1;

	assign tick_next = {1'b0, tick_q} + 1'b1;
	assign sample    = tick_next >= {1'b0, interval_q};

	// jump condition
	always_comb begin
		unique case (uw.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_IN:     jump = !s_tvalid;
			C_SKIP:      jump = skip_q;
			C_DIV_MORE:  jump = !div_last;
			C_WALK_MORE: jump = wi_q < fill_q;
			C_OUT_BUSY:  jump = out_busy;
			default:     jump = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (jump) begin
			step_q <= uw.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	// divider operand select
	always_comb begin
		div_ctrl.load = (uw.op == OP_DIV_RATE) || (uw.op == OP_DIV_MEAN);
		div_ctrl.step = (uw.op == OP_DIV_STEP);
		if (uw.op == OP_DIV_MEAN) begin
			div_dividend = sum_q;
			div_divisor  = VW'(fill_q);
		end else begin
			div_dividend = SW'(RATE_NUM);
			div_divisor  = VW'(delta_q);
		end
	end

	fsw_div #(
		.DIVIDEND_W (SW),
		.DIVISOR_W  (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.last     (div_last)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	// control state: tick counter, ring pointer, fill count, statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			skip_q  <= 1'b1;
			rec_q   <= 1'b0;
			wslot_q <= '0;
			fill_q  <= '0;
			wi_q    <= '0;
			rd_v_s1 <= 1'b0;
			cur_q   <= '0;
			mean_q  <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else begin
			case (uw.op)
				OP_ACCEPT: begin
					if (in_fire) begin
						tick_q <= sample ? '0 : tick_next[INT_W-1:0];
						skip_q <= !(sample && s_tdata != '0);
						rec_q  <= 1'b0;
					end
				end
				OP_STORE: begin
					cur_q   <= div_quo[RATE_W-1:0];
					rec_q   <= 1'b1;
					wslot_q <= (wslot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
					if (fill_q != CW'(HISTORY_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end
					wi_q    <= '0;
					rd_v_s1 <= 1'b0;
				end
				OP_WALK: begin
					if (wi_q < fill_q) begin
						wi_q    <= wi_q + 1'b1;
						rd_v_s1 <= 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
					end
				end
				OP_STAT: begin
					mean_q <= div_quo[RATE_W-1:0];
					min_q  <= lo_q;
					max_q  <= hi_q;
				end
				default: begin
				end
			endcase
		end
	end

	// input latch and walk accumulators
	always_ff @(posedge clk) begin
		if (in_fire) begin
			delta_q <= s_tdata;
		end
		if (uw.op == OP_STORE) begin
			sum_q <= '0;
			lo_q  <= '1;
			hi_q  <= '0;
		end else if (uw.op == OP_WALK && rd_v_s1) begin
			sum_q <= sum_q + SW'(rd_data_s1);
			if (rd_data_s1 < lo_q) begin
				lo_q <= rd_data_s1;
			end
			if (rd_data_s1 > hi_q) begin
				hi_q <= rd_data_s1;
			end
		end
	end

	// history memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (uw.op == OP_STORE) begin
			mem[wslot_q] <= div_quo[RATE_W-1:0];
		end
		rd_data_s1 <= mem[wi_q[AW-1:0]];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tuser_q <= rec_q;
			m_tdata_q <= {max_q, min_q, mean_q, cur_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* design/fsw_div.sv */
module fsw_div #(
	parameter int DIVIDEND_W = 36,
	parameter int DIVISOR_W  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fsw_pkg::div_ctrl_t    ctrl,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic                  last
);
	import fsw_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dv_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;

	// one restoring step: shift in next dividend bit, try subtract
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dv_q};
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= CNT_W'(DIVIDEND_W);
		end else if (ctrl.step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (ctrl.step) begin
			if (diff[DIVISOR_W]) begin
				rem_q <= trial[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end else begin
				rem_q <= diff[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end
		end
	end

	assign quotient = quo_q;
	assign last     = (cnt_q == CNT_W'(1));

endmodule

/* tb/frame_rate_window_statistics_test.sv */
module frame_rate_window_statistics_test;

	import fsw_pkg::*;

	localparam int RING_DEPTH = 128;
	localparam int SETTLE_CYCLES = 240;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 146;

	// one result item as seen on the m_ stream
	typedef struct packed {
		logic              recorded;
		logic [RATE_W-1:0] current_rate;
		logic [RATE_W-1:0] mean_rate;
		logic [RATE_W-1:0] min_rate;
		logic [RATE_W-1:0] max_rate;
	} frame_stats_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [INT_W-1:0]    cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [DELTA_W-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [111:0]        m_tdata;
	logic                m_tuser;

	// stimulus and expectation stores
	logic [DELTA_W-1:0]  pending_deltas[$];
	frame_stats_t        expected_stats[$];
	logic                in_fire;
	int unsigned         cfg_writes;
	int unsigned         send_idle;
	int unsigned         recv_idle;
	int unsigned         mismatches;

	// predictor state
	logic [INT_W-1:0]    sample_every;
	logic [INT_W-1:0]    tick_run;
	int unsigned         ring_slot;
	logic [RATE_W-1:0]   rate_ring[RING_DEPTH];
	logic [RATE_W-1:0]   held_cur;
	logic [RATE_W-1:0]   held_mean;
	logic [RATE_W-1:0]   held_min;
	logic [RATE_W-1:0]   held_max;

	frame_rate_window_statistics #(
		.HISTORY_DEPTH(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// advance one frame tick and return the statistics it yields
	function automatic frame_stats_t advance_frame_tick(input logic [DELTA_W-1:0] delta);
		frame_stats_t      r;
		int unsigned       next_run;
		logic [RATE_W-1:0] rate;
		longint unsigned   sum;
		int unsigned       cnt;
		logic [RATE_W-1:0] lo;
		logic [RATE_W-1:0] hi;
		r.recorded = 1'b0;
		next_run = tick_run + 1;
		if (next_run >= sample_every) begin
			tick_run = '0;
			if (delta != '0) begin
				rate = RATE_W'(32'(RATE_NUM) / 32'(delta));
				rate_ring[ring_slot] = rate;
				ring_slot = (ring_slot + 1) % RING_DEPTH;
				held_cur = rate;
				// walk the ring over valid slots
				sum = 0;
				cnt = 0;
				lo = '0;
				hi = '0;
				for (int i = 0; i < RING_DEPTH; i++) begin
					if (rate_ring[i] != '0) begin
						sum += rate_ring[i];
						if (cnt == 0 || rate_ring[i] < lo)
							lo = rate_ring[i];
						if (rate_ring[i] > hi)
							hi = rate_ring[i];
						cnt++;
					end
				end
				held_mean = (cnt != 0) ? RATE_W'(sum / cnt) : '0;
				held_min = lo;
				held_max = hi;
				r.recorded = 1'b1;
			end
		end else begin
			tick_run = next_run[INT_W-1:0];
		end
		r.current_rate = held_cur;
		r.mean_rate = held_mean;
		r.min_rate = held_min;
		r.max_rate = held_max;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [RATE_W-1:0] got,
			input logic [RATE_W-1:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// sender: presents queued frame ticks with random gaps, drives a random m_tready
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_fire) begin
				if (pending_deltas.size() != 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_deltas.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end else begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			m_tready <= 1'b0;
		end
	end

	// monitor: checks result items, tracks config writes, predicts accepted ticks
	always @(posedge clk or negedge arst_n) begin
		frame_stats_t got;
		frame_stats_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
			cfg_writes = 0;
			mismatches = 0;
			sample_every = 6'd1;
			tick_run = '0;
			ring_slot = 0;
			held_cur = '0;
			held_mean = '0;
			held_min = '0;
			held_max = '0;
			for (int i = 0; i < RING_DEPTH; i++)
				rate_ring[i] = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.recorded = m_tuser;
				got.current_rate = m_tdata[27:0];
				got.mean_rate = m_tdata[55:28];
				got.min_rate = m_tdata[83:56];
				got.max_rate = m_tdata[111:84];
				if (expected_stats.size() == 0) begin
					report_mismatch("unexpected item", got.current_rate, '0);
				end else begin
					want = expected_stats.pop_front();
					if (got.recorded != want.recorded)
						report_mismatch("recorded", RATE_W'(got.recorded),
							RATE_W'(want.recorded));
					if (got.current_rate != want.current_rate)
						report_mismatch("current_rate", got.current_rate, want.current_rate);
					if (got.mean_rate != want.mean_rate)
						report_mismatch("mean_rate", got.mean_rate, want.mean_rate);
					if (got.min_rate != want.min_rate)
						report_mismatch("min_rate", got.min_rate, want.min_rate);
					if (got.max_rate != want.max_rate)
						report_mismatch("max_rate", got.max_rate, want.max_rate);
				end
			end
			if (cfg_valid && cfg_ready) begin
				sample_every = cfg_data;
				cfg_writes++;
			end
			if (s_tvalid && s_tready)
				expected_stats.push_back(advance_frame_tick(s_tdata));
			in_fire <= s_tvalid && s_tready;
		end
	end

	// wait until the block is idle, then write the sample interval
	task automatic set_interval(input logic [INT_W-1:0] value);
		int unsigned target;
		while (pending_deltas.size() != 0 || s_tvalid || expected_stats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		target = cfg_writes + 1;
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(negedge clk);
		while (cfg_writes != target);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DELTA_W-1:0] random_delta();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return '0;
		else if (pick < 16)
			return DELTA_W'($urandom_range(1, 64));
		else if (pick < 24)
			return 24'hFFFFFF - DELTA_W'($urandom_range(0, 255));
		else if (pick < 70)
			return DELTA_W'($urandom_range(4000, 100000));
		else
			return DELTA_W'($urandom());
	endfunction

	// stimulus
	initial begin
		logic [INT_W-1:0] phase_interval[RANDOM_PHASES];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle = 24;
		recv_idle = 70;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// every tick samples: extremes of the delta and a zero delta
		set_interval(6'd1);
		pending_deltas.push_back(24'd1);
		pending_deltas.push_back(24'hFFFFFF);
		pending_deltas.push_back(24'd0);
		pending_deltas.push_back(24'h555555);
		pending_deltas.push_back(24'hAAAAAA);
		pending_deltas.push_back(24'd16666);
		pending_deltas.push_back(24'd33333);

		// skipped ticks, zero delta on a skipped and on a sampling tick
		set_interval(6'd3);
		pending_deltas.push_back(24'd0);
		pending_deltas.push_back(24'd500);
		pending_deltas.push_back(24'd0);
		pending_deltas.push_back(24'd1000);
		pending_deltas.push_back(24'd2000);

		// interval of 60, then lowered below the running count
		set_interval(6'd60);
		repeat (4) pending_deltas.push_back(24'd12345);
		set_interval(6'd2);
		pending_deltas.push_back(24'd7000);

		// zero interval samples every tick, then the widest value
		set_interval(6'd0);
		pending_deltas.push_back(24'd2);
		pending_deltas.push_back(24'd3);
		pending_deltas.push_back(24'd250000);
		set_interval(6'd63);
		pending_deltas.push_back(24'd40000);
		pending_deltas.push_back(24'd41000);

		// random phases over several intervals and idling modes
		phase_interval = '{6'd1, 6'd2, 6'd0, 6'd1, 6'd63, 6'd3,
			6'd1, 6'd60, 6'd1, 6'd5, 6'd1, 6'd4};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 4) begin
				send_idle = 24;
				recv_idle = 70;
			end else if (p < 8) begin
				send_idle = 70;
				recv_idle = 24;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (p == 9)
				phase_interval[p] = INT_W'($urandom_range(1, 8));
			set_interval(phase_interval[p]);
			repeat (PHASE_ITEMS) pending_deltas.push_back(random_delta());
		end

		// drain and settle
		while (pending_deltas.size() != 0 || s_tvalid || expected_stats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_stats.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// run limit
	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

endmodule
